// File: hw/rtl/one_wire_bus_master_assert.svh
// assertion macros for the single-wire bus master
// used by one_wire_bus_master.sv, expects clk and rst_n in scope
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("single-wire bus master assertion failed");

// next-cycle implication, checked outside reset
`define OWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("single-wire bus master assertion failed");

`endif

// File: hw/rtl/owm_pkg.sv
// shared constants and helpers for the single-wire bus master
// no dependencies
package owm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int TIME_W        = 10;
  localparam int BITS_W        = 4;
  localparam int NUM_REGS      = 7;
  localparam int ADDR_W        = 5;

  // command codes
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_RESET    = 3'd1;
  localparam logic [2:0] CMD_WR_BIT   = 3'd2;
  localparam logic [2:0] CMD_RD_BIT   = 3'd3;
  localparam logic [2:0] CMD_WR_BYTE  = 3'd4;
  localparam logic [2:0] CMD_RD_BYTE  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SHORT_PULSE   = 3'd3;
  localparam logic [2:0] REG_SLOT_LONG     = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_READ_TAIL     = 3'd6;

  // register reset values
  localparam logic [TIME_W-1:0] RST_RESET_LOW     = 10'd480;
  localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT = 10'd80;
  localparam logic [TIME_W-1:0] RST_RESET_TAIL    = 10'd400;
  localparam logic [TIME_W-1:0] RST_SHORT_PULSE   = 10'd2;
  localparam logic [TIME_W-1:0] RST_SLOT_LONG     = 10'd60;
  localparam logic [TIME_W-1:0] RST_READ_SAMPLE   = 10'd12;
  localparam logic [TIME_W-1:0] RST_READ_TAIL     = 10'd50;

  typedef logic [TIME_W-1:0] time_t;

  // a programmed time of zero lasts one tick
  function automatic time_t dur(input time_t v);
    dur = (v == '0) ? time_t'(1) : v;
  endfunction

endpackage

// File: hw/rtl/one_wire_bus_master.sv
// Single-wire bus master. Each input transfer is one microsecond tick carrying
// an optional command and the sampled bus level; each tick yields one result
// transfer with the bus drive and status flags for that tick.
// Channels: in_* valid/ready (command, write data, line level), out_* valid/ready
// (drive_low, busy, done, read data, presence, rejected), APB-style register
// port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holding seven 10-bit
// timing registers at byte addresses 0, 4, ... 24.
// An accepted tick is held in the input register, passes through the sequencer
// step into the result register, and its result transfer is offered from there.
// Throughput: one tick per cycle while the receiver keeps out_ready high; the
// sequencer step is a single short decrement-and-compare on the tick timer
// between the two registers.
// Reset (rst_n low, synchronous): the sequencer goes idle, both stages empty,
// timing registers return to their defaults, read data and presence clear.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready drops; no tick is lost and sequencer state only moves
// when a tick passes into the result register.
// Timing registers are meant to be written while no operation is running.
module one_wire_bus_master
  import owm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // tick input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_command,
  input  logic [7:0]        in_write_data,
  input  logic              in_line_level,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_drive_low,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [7:0]        out_read_data,
  output logic              out_presence,
  output logic              out_rejected,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_TAIL = 3'd3;
  localparam logic [2:0] PH_SLOT_LOW = 3'd4;
  localparam logic [2:0] PH_SLOT_REL = 3'd5;
  localparam logic [2:0] PH_RD_WAIT  = 3'd6;
  localparam logic [2:0] PH_RD_TAIL  = 3'd7;

  // timing registers
  time_t reset_low_r, presence_wait_r, reset_tail_r, short_pulse_r;
  time_t slot_long_r, read_sample_r, read_tail_r;

  // input stage
  logic        s1_valid_r;
  logic [2:0]  s1_cmd_r;
  logic [7:0]  s1_wd_r;
  logic        s1_line_r;

  // sequencer state
  logic [2:0]        phase_r, phase_nxt;
  logic [2:0]        op_r, op_nxt;
  time_t             timer_r, timer_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              pres_r, pres_nxt;
  logic [7:0]        last_r, last_nxt;

  // result register
  logic out_valid_r;
  logic drive_r, busy_r, done_r, rej_r;
  logic drive_nxt, busy_nxt, done_nxt, rej_nxt;

  logic adv;
  logic wr_en;
  logic [2:0] reg_idx;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= RST_RESET_LOW;
      presence_wait_r <= RST_PRESENCE_WAIT;
      reset_tail_r    <= RST_RESET_TAIL;
      short_pulse_r   <= RST_SHORT_PULSE;
      slot_long_r     <= RST_SLOT_LONG;
      read_sample_r   <= RST_READ_SAMPLE;
      read_tail_r     <= RST_READ_TAIL;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_RESET_LOW:     reset_low_r     <= pwdata[TIME_W-1:0];
        REG_PRESENCE_WAIT: presence_wait_r <= pwdata[TIME_W-1:0];
        REG_RESET_TAIL:    reset_tail_r    <= pwdata[TIME_W-1:0];
        REG_SHORT_PULSE:   short_pulse_r   <= pwdata[TIME_W-1:0];
        REG_SLOT_LONG:     slot_long_r     <= pwdata[TIME_W-1:0];
        REG_READ_SAMPLE:   read_sample_r   <= pwdata[TIME_W-1:0];
        REG_READ_TAIL:     read_tail_r     <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_RESET_LOW:     prdata = 32'(reset_low_r);
        REG_PRESENCE_WAIT: prdata = 32'(presence_wait_r);
        REG_RESET_TAIL:    prdata = 32'(reset_tail_r);
        REG_SHORT_PULSE:   prdata = 32'(short_pulse_r);
        REG_SLOT_LONG:     prdata = 32'(slot_long_r);
        REG_READ_SAMPLE:   prdata = 32'(read_sample_r);
        REG_READ_TAIL:     prdata = 32'(read_tail_r);
        default:           prdata = '0;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_wd_r   <= in_write_data;
      s1_line_r <= in_line_level;
    end
  end

  // sequencer step for one tick
  always_comb begin
    logic is_read;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    timer_nxt = timer_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    last_nxt  = last_r;
    drive_nxt = 1'b0;
    busy_nxt  = 1'b0;
    done_nxt  = 1'b0;
    rej_nxt   = 1'b0;

    // command start when idle; any command while busy is rejected
    if (phase_r == PH_IDLE) begin
      if (s1_cmd_r != CMD_NONE && s1_cmd_r <= CMD_RD_BYTE) begin
        op_nxt = s1_cmd_r;
        if (s1_cmd_r == CMD_RESET) begin
          phase_nxt = PH_RST_LOW;
          timer_nxt = dur(reset_low_r);
        end else begin
          case (s1_cmd_r)
            CMD_WR_BIT: begin
              shift_nxt = {7'd0, s1_wd_r[0]};
              bits_nxt  = BITS_W'(1);
            end
            CMD_WR_BYTE: begin
              shift_nxt = s1_wd_r;
              bits_nxt  = BITS_W'(BITS_PER_BYTE);
            end
            CMD_RD_BIT: begin
              shift_nxt = '0;
              bits_nxt  = BITS_W'(1);
            end
            default: begin
              shift_nxt = '0;
              bits_nxt  = BITS_W'(BITS_PER_BYTE);
            end
          endcase
          phase_nxt = PH_SLOT_LOW;
          timer_nxt = (s1_cmd_r == CMD_RD_BIT || s1_cmd_r == CMD_RD_BYTE || shift_nxt[0])
                      ? dur(short_pulse_r) : dur(slot_long_r);
        end
      end
    end else if (s1_cmd_r != CMD_NONE) begin
      rej_nxt = 1'b1;
    end

    is_read = (op_nxt == CMD_RD_BIT) || (op_nxt == CMD_RD_BYTE);

    // run the current phase
    if (phase_nxt != PH_IDLE) begin
      busy_nxt  = 1'b1;
      drive_nxt = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_LOW);
      timer_nxt = timer_nxt - time_t'(1);
      if (timer_nxt == '0) begin
        case (phase_nxt)
          PH_RST_LOW: begin
            phase_nxt = PH_RST_WAIT;
            timer_nxt = dur(presence_wait_r);
          end
          PH_RST_WAIT: begin
            pres_nxt  = !s1_line_r;
            phase_nxt = PH_RST_TAIL;
            timer_nxt = dur(reset_tail_r);
          end
          PH_RST_TAIL: begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
          PH_SLOT_LOW: begin
            if (is_read) begin
              phase_nxt = PH_RD_WAIT;
              timer_nxt = dur(read_sample_r);
            end else begin
              phase_nxt = PH_SLOT_REL;
              timer_nxt = shift_nxt[0] ? dur(slot_long_r) : dur(short_pulse_r);
            end
          end
          PH_SLOT_REL: begin
            shift_nxt = {1'b0, shift_nxt[7:1]};
            bits_nxt  = bits_nxt - BITS_W'(1);
            if (bits_nxt == '0) begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_SLOT_LOW;
              timer_nxt = shift_nxt[0] ? dur(short_pulse_r) : dur(slot_long_r);
            end
          end
          PH_RD_WAIT: begin
            shift_nxt = {s1_line_r, shift_nxt[7:1]};
            phase_nxt = PH_RD_TAIL;
            timer_nxt = dur(read_tail_r);
          end
          default: begin
            bits_nxt = bits_nxt - BITS_W'(1);
            if (bits_nxt == '0) begin
              last_nxt  = shift_nxt;
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_SLOT_LOW;
              timer_nxt = dur(short_pulse_r);
            end
          end
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= CMD_NONE;
      timer_r <= '0;
      bits_r  <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      last_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      timer_r <= timer_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      last_r  <= last_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r <= drive_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      rej_r   <= rej_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_low = drive_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_read_data = last_r;
  assign out_presence  = pres_r;
  assign out_rejected  = rej_r;

  // checks
`include "one_wire_bus_master_assert.svh"

  `OWM_ASSERT_IMPL(a_done_is_busy, out_valid_r && done_r, busy_r)
  `OWM_ASSERT_IMPL(a_drive_is_busy, out_valid_r && drive_r, busy_r)
  `OWM_ASSERT_IMPL(a_bits_in_range, 1'b1, bits_r <= BITS_W'(BITS_PER_BYTE))
  `OWM_ASSERT_NEXT(a_idle_holds, adv && phase_r == PH_IDLE && s1_cmd_r == CMD_NONE,
                   phase_r == PH_IDLE)
  `OWM_ASSERT_NEXT(a_state_frozen, !adv, phase_r == $past(phase_r) && timer_r == $past(timer_r))

endmodule
